/* hdl/fmr_pkg.sv */
// ----------------------------------------------------------------------------
// fmr_pkg
// Shared types, constants and the message ID table of the framed receiver.
// ----------------------------------------------------------------------------
package fmr_pkg;

  localparam int MESSAGE_SLOTS = 11;
  localparam int SLOT_BYTES    = 64;
  localparam int FRAME_CAP     = SLOT_BYTES + 2;
  localparam int FB_AW         = $clog2(FRAME_CAP);
  localparam int SM_DEPTH      = MESSAGE_SLOTS * SLOT_BYTES;
  localparam int SM_AW         = $clog2(SM_DEPTH);
  localparam int FILL_W        = $clog2(SLOT_BYTES + 1);
  localparam int SIDX_W        = (MESSAGE_SLOTS > 1) ? $clog2(MESSAGE_SLOTS) : 1;
  localparam int CNT_W         = 9;
  localparam int ID_COUNT      = 11;

  localparam logic [7:0] ID_TABLE [ID_COUNT] = '{
    8'h31, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h41, 8'h42, 8'h45
  };

  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_TICK = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;

  localparam logic [2:0] EV_STORED  = 3'd0;
  localparam logic [2:0] EV_DROPPED = 3'd1;
  localparam logic [2:0] EV_EXPIRED = 3'd2;
  localparam logic [2:0] EV_ABORTED = 3'd3;
  localparam logic [2:0] EV_READ    = 3'd4;
  localparam logic [2:0] EV_NOTHING = 3'd5;

  localparam logic [1:0] REG_START_BYTE = 2'd0;
  localparam logic [1:0] REG_MSG_TMO    = 2'd1;
  localparam logic [1:0] REG_FRAME_TMO  = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] rx_byte;
    logic [3:0] read_slot;
    logic [5:0] read_offset;
  } in_item_t;

  typedef struct packed {
    logic [2:0] event_res;
    logic [3:0] slot;
    logic [7:0] data_byte;
    logic       last;
  } out_item_t;

  typedef enum logic [1:0] {OP_BYTE, OP_TICK, OP_READ, OP_NOP} op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] rx_byte;
    logic [3:0] read_slot;
    logic [5:0] read_offset;
  } cmd_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] idx;
  } id_hit_t;

  function automatic id_hit_t id_lookup(input logic [7:0] b);
    id_hit_t r;
    r = '0;
    for (int i = ID_COUNT - 1; i >= 0; i--) begin
      if (ID_TABLE[i] == b) begin
        r.hit = (i < MESSAGE_SLOTS);
        r.idx = 4'(i);
      end
    end
    return r;
  endfunction

endpackage

/* hdl/fmr_front.sv */
// ----------------------------------------------------------------------------
// fmr_front
// Input acceptance, classification and a two-entry command queue.
// ----------------------------------------------------------------------------
module fmr_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  fmr_pkg::in_item_t in_data,
  output logic             cmd_valid,
  output fmr_pkg::cmd_t    cmd,
  input  logic             cmd_pop
);
  import fmr_pkg::*;

  cmd_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  cmd_t       cls;
  logic       push;
  logic       pop;

  always_comb begin
    cls.rx_byte     = in_data.rx_byte;
    cls.read_slot   = in_data.read_slot;
    cls.read_offset = in_data.read_offset;
    unique case (in_data.kind)
      KIND_BYTE: cls.op = OP_BYTE;
      KIND_TICK: cls.op = OP_TICK;
      KIND_READ: cls.op = OP_READ;
      default:   cls.op = OP_NOP;
    endcase
  end

  assign in_ready  = (count != 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_pop && cmd_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= cls;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

/* hdl/fmr_back.sv */
// ----------------------------------------------------------------------------
// fmr_back
// Frame assembly, slot store, tick ageing, reads and the result register.
// ----------------------------------------------------------------------------
module fmr_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  input  fmr_pkg::cmd_t     cmd,
  output logic              cmd_pop,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  output logic              out_valid,
  input  logic              out_ready,
  output fmr_pkg::out_item_t out_data
);
  import fmr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_BYTE, S_COPY, S_STORE, S_READ, S_READ_OUT,
    S_WALK, S_TICK_END, S_ABORT, S_NOP
  } state_t;

  typedef enum logic [1:0] {PH_HUNT, PH_LEN, PH_DATA} phase_t;

  state_t state;
  cmd_t   cmd_q;

  logic [7:0]  start_byte;
  logic [15:0] msg_tmo;
  logic [15:0] frame_tmo;

  phase_t             rx_phase;
  logic [CNT_W-1:0]   byte_count;
  logic [7:0]         frame_length;
  logic [15:0]        frame_age;
  logic [7:0]         id_byte;

  logic [FILL_W-1:0]  slot_fill   [MESSAGE_SLOTS];
  logic               slot_active [MESSAGE_SLOTS];
  logic [15:0]        slot_age    [MESSAGE_SLOTS];

  logic [7:0]         fb_mem [FRAME_CAP];
  logic [7:0]         fb_q;
  logic [7:0]         sm_mem [SM_DEPTH];
  logic [7:0]         sm_q;

  logic [FILL_W-1:0]  rd_k;
  logic [FILL_W-1:0]  wr_k;
  logic               wr_pend;
  logic [3:0]         copy_idx;
  logic [FILL_W-1:0]  copy_n;
  logic               read_ok;

  logic [SIDX_W-1:0]  walk;
  logic               pend_valid;
  logic [3:0]         pend_slot;

  logic               can_emit;
  logic [CNT_W-1:0]   cnt_inc;
  logic               frame_done;
  logic [7:0]         id_now;
  id_hit_t            lk;
  logic [FILL_W-1:0]  nfill;
  logic               fb_we;
  logic [FB_AW-1:0]   fb_raddr;
  logic [SM_AW-1:0]   sm_waddr;
  logic [SM_AW-1:0]   sm_raddr;
  logic [3:0]         sidx;
  logic               sv;
  logic [FILL_W-1:0]  fill_r;
  logic               act_r;
  logic [15:0]        age_r;
  logic [15:0]        age_inc;
  logic               expire;
  logic [15:0]        fage_new;
  logic               abort;

  assign cfg_ready = 1'b1;
  assign can_emit  = !out_valid || out_ready;
  assign cmd_pop   = (state == S_IDLE);

  assign cnt_inc    = byte_count + CNT_W'(1);
  assign frame_done = cnt_inc >= (CNT_W'(frame_length) + CNT_W'(2));
  assign id_now     = (byte_count == CNT_W'(3)) ? cmd_q.rx_byte : id_byte;
  assign lk         = id_lookup(id_now);
  assign nfill      = ({1'b0, frame_length} > 9'(SLOT_BYTES)) ? FILL_W'(SLOT_BYTES)
                                                             : FILL_W'(frame_length);
  assign fb_we      = (state == S_BYTE) && can_emit && (rx_phase == PH_DATA)
                      && (byte_count < CNT_W'(FRAME_CAP));
  assign fb_raddr   = FB_AW'(rd_k) + FB_AW'(2);
  assign sm_waddr   = SM_AW'(copy_idx) * SM_AW'(SLOT_BYTES) + SM_AW'(wr_k);
  assign sm_raddr   = SM_AW'(cmd_q.read_slot) * SM_AW'(SLOT_BYTES)
                      + SM_AW'(cmd_q.read_offset);

  assign sidx    = (state == S_READ) ? cmd_q.read_slot : 4'(walk);
  assign sv      = (sidx < 4'(MESSAGE_SLOTS));
  assign fill_r  = sv ? slot_fill[sidx[SIDX_W-1:0]]   : '0;
  assign act_r   = sv ? slot_active[sidx[SIDX_W-1:0]] : 1'b0;
  assign age_r   = sv ? slot_age[sidx[SIDX_W-1:0]]    : '0;
  assign age_inc = (age_r != 16'hFFFF) ? age_r + 16'd1 : age_r;
  assign expire  = act_r && (age_inc > msg_tmo);

  assign fage_new = ((rx_phase != PH_HUNT) && (frame_age != 16'hFFFF))
                    ? frame_age + 16'd1 : frame_age;
  assign abort    = fage_new > frame_tmo;

  always_ff @(posedge clk) begin
    if (fb_we) begin
      fb_mem[byte_count[FB_AW-1:0]] <= cmd_q.rx_byte;
    end
    fb_q <= fb_mem[fb_raddr];
  end

  always_ff @(posedge clk) begin
    if (wr_pend) begin
      sm_mem[sm_waddr] <= fb_q;
    end
    sm_q <= sm_mem[sm_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      start_byte <= 8'h0A;
      msg_tmo    <= 16'd3000;
      frame_tmo  <= 16'd2;
      rx_phase   <= PH_HUNT;
      byte_count <= '0;
      frame_length <= '0;
      frame_age  <= '0;
      out_valid  <= 1'b0;
      wr_pend    <= 1'b0;
      pend_valid <= 1'b0;
      for (int i = 0; i < MESSAGE_SLOTS; i++) begin
        slot_fill[i]   <= '0;
        slot_active[i] <= 1'b0;
        slot_age[i]    <= '0;
      end
    end else begin
      if (out_ready) out_valid <= 1'b0;
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_START_BYTE: start_byte <= cfg_data[7:0];
          REG_MSG_TMO:    msg_tmo    <= cfg_data;
          REG_FRAME_TMO:  frame_tmo  <= cfg_data;
          default: ;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cmd_q <= cmd;
            walk  <= '0;
            unique case (cmd.op)
              OP_BYTE: state <= S_BYTE;
              OP_TICK: state <= S_WALK;
              OP_READ: state <= S_READ;
              default: state <= S_NOP;
            endcase
          end
        end

        S_BYTE: begin
          if (can_emit) begin
            unique case (rx_phase)
              PH_HUNT: begin
                out_valid <= 1'b1;
                out_data  <= '{event_res: EV_NOTHING, slot: 4'd0, data_byte: 8'd0, last: 1'b1};
                state     <= S_IDLE;
                frame_age <= '0;
                if (cmd_q.rx_byte == start_byte) begin
                  byte_count <= CNT_W'(1);
                  rx_phase   <= PH_LEN;
                end
              end
              PH_LEN: begin
                out_valid    <= 1'b1;
                out_data     <= '{event_res: EV_NOTHING, slot: 4'd0, data_byte: 8'd0,
                                  last: 1'b1};
                state        <= S_IDLE;
                frame_length <= cmd_q.rx_byte;
                byte_count   <= CNT_W'(2);
                rx_phase     <= PH_DATA;
              end
              default: begin
                if (byte_count == CNT_W'(3)) id_byte <= cmd_q.rx_byte;
                if (frame_done) begin
                  rx_phase   <= PH_HUNT;
                  byte_count <= '0;
                  frame_age  <= '0;
                  if (frame_length < 8'd2 || !lk.hit) begin
                    out_valid <= 1'b1;
                    out_data  <= '{event_res: EV_DROPPED, slot: 4'd0, data_byte: 8'd0,
                                   last: 1'b1};
                    state     <= S_IDLE;
                  end else begin
                    copy_idx  <= lk.idx;
                    copy_n    <= nfill;
                    rd_k      <= '0;
                    state     <= S_COPY;
                  end
                end else begin
                  byte_count <= cnt_inc;
                  out_valid  <= 1'b1;
                  out_data   <= '{event_res: EV_NOTHING, slot: 4'd0, data_byte: 8'd0,
                                  last: 1'b1};
                  state      <= S_IDLE;
                end
              end
            endcase
          end
        end

        S_COPY: begin
          if (rd_k != copy_n) begin
            wr_pend <= 1'b1;
            wr_k    <= rd_k;
            rd_k    <= rd_k + FILL_W'(1);
          end else begin
            wr_pend <= 1'b0;
            if (!wr_pend) state <= S_STORE;
          end
        end

        S_STORE: begin
          if (can_emit) begin
            slot_fill[copy_idx[SIDX_W-1:0]]   <= copy_n;
            slot_active[copy_idx[SIDX_W-1:0]] <= 1'b1;
            slot_age[copy_idx[SIDX_W-1:0]]    <= '0;
            out_valid <= 1'b1;
            out_data  <= '{event_res: EV_STORED, slot: copy_idx, data_byte: 8'd0, last: 1'b1};
            state     <= S_IDLE;
          end
        end

        S_READ: begin
          read_ok <= sv && (FILL_W'(cmd_q.read_offset) < fill_r)
                     && (9'(cmd_q.read_offset) < 9'(SLOT_BYTES));
          state   <= S_READ_OUT;
        end

        S_READ_OUT: begin
          if (can_emit) begin
            out_valid <= 1'b1;
            out_data  <= '{event_res: EV_READ, slot: cmd_q.read_slot,
                           data_byte: read_ok ? sm_q : 8'd0, last: 1'b1};
            state     <= S_IDLE;
          end
        end

        S_WALK: begin
          if (!(expire && pend_valid && !can_emit)) begin
            if (act_r) begin
              if (expire) begin
                slot_active[walk] <= 1'b0;
                slot_age[walk]    <= '0;
                slot_fill[walk]   <= '0;
                if (pend_valid) begin
                  out_valid <= 1'b1;
                  out_data  <= '{event_res: EV_EXPIRED, slot: pend_slot,
                                 data_byte: 8'd0, last: 1'b0};
                end
                pend_valid <= 1'b1;
                pend_slot  <= 4'(walk);
              end else begin
                slot_age[walk] <= age_inc;
              end
            end else begin
              slot_age[walk] <= '0;
            end
            walk <= walk + SIDX_W'(1);
            if (walk == SIDX_W'(MESSAGE_SLOTS - 1)) state <= S_TICK_END;
          end
        end

        S_TICK_END: begin
          if (can_emit) begin
            out_valid <= 1'b1;
            if (abort) begin
              rx_phase   <= PH_HUNT;
              byte_count <= '0;
              frame_age  <= '0;
            end else begin
              frame_age <= fage_new;
            end
            if (pend_valid) begin
              out_data   <= '{event_res: EV_EXPIRED, slot: pend_slot,
                              data_byte: 8'd0, last: !abort};
              pend_valid <= 1'b0;
              state      <= abort ? S_ABORT : S_IDLE;
            end else begin
              out_data <= '{event_res: abort ? EV_ABORTED : EV_NOTHING, slot: 4'd0,
                            data_byte: 8'd0, last: 1'b1};
              state    <= S_IDLE;
            end
          end
        end

        S_ABORT: begin
          if (can_emit) begin
            out_valid <= 1'b1;
            out_data  <= '{event_res: EV_ABORTED, slot: 4'd0, data_byte: 8'd0, last: 1'b1};
            state     <= S_IDLE;
          end
        end

        default: begin
          if (can_emit) begin
            out_valid <= 1'b1;
            out_data  <= '{event_res: EV_NOTHING, slot: 4'd0, data_byte: 8'd0, last: 1'b1};
            state     <= S_IDLE;
          end
        end
      endcase
    end
  end

  a_copy_in_copy: assert property (@(posedge clk) disable iff (rst)
    wr_pend |-> (state == S_COPY))
    else $error("slot write outside copy");

  a_hunt_age: assert property (@(posedge clk) disable iff (rst)
    (rx_phase == PH_HUNT) |-> (frame_age == 16'd0))
    else $error("frame age running while hunting");

  a_hunt_count: assert property (@(posedge clk) disable iff (rst)
    (rx_phase == PH_HUNT) |-> (byte_count == '0))
    else $error("byte count not cleared while hunting");

  a_expired_slot: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.event_res == EV_EXPIRED) |-> (out_data.slot < 4'(MESSAGE_SLOTS)))
    else $error("expiry on a slot that does not exist");

endmodule

/* hdl/framed_message_receiver_with_timeouts_top.sv */
// ----------------------------------------------------------------------------
// framed_message_receiver_with_timeouts_top
// Framed byte receiver with an eleven-slot message store and tick timeouts.
// ----------------------------------------------------------------------------
// One input beat is a received byte, a timer tick or a slot read. The byte that
// completes a stored frame starts a copy of n payload bytes from the frame buffer
// into the slot memory, one byte per cycle over its single write port. A tick
// walks the slots one per cycle, except while an expiry waits on the result side.
// A read goes through the registered slot memory port. A two-beat queue takes
// inputs while the engine works, and a result register holds one beat.
module framed_message_receiver_with_timeouts_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  fmr_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output fmr_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import fmr_pkg::*;

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;

  fmr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  fmr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
